// ----- rtl/core/httptok_pkg.sv -----
`default_nettype none

package httptok_pkg;

    localparam logic [2:0] KIND_METHOD = 3'd0;
    localparam logic [2:0] KIND_TARGET = 3'd1;
    localparam logic [2:0] KIND_VERSION = 3'd2;
    localparam logic [2:0] KIND_NAME = 3'd3;
    localparam logic [2:0] KIND_VALUE = 3'd4;
    localparam logic [2:0] KIND_BODY = 3'd5;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] token_kind;
        logic       token_end;
        logic       closed_early;
        logic       last_of_run;
    } result_t;

    function automatic result_t make_result(
        input logic [7:0] b,
        input logic       v,
        input logic [2:0] k,
        input logic       e,
        input logic       c
    );
        result_t r;
        r.out_byte = b;
        r.byte_valid = v;
        r.token_kind = k;
        r.token_end = e;
        r.closed_early = c;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/http_request_tokenizer_core.sv -----
`default_nettype none
// HTTP/1.1 request tokenizer.
// Input channel (in_valid/in_stall): one request byte per item, or an
// end_of_stream item that carries no byte. Output channel (out_valid/
// out_stall): one result item per handshake: a tagged token byte or a
// token end marker; last_of_run flags the final result of an input item.
// An input item yields zero, one or two results. The state update and the
// results are computed in the cycle of acceptance and written into a
// four-entry result queue; if it was empty, the first result is offered the
// next cycle. One byte per cycle while each byte yields at most one result
// and out_stall is low; a byte's two results leave one per handshake.
// The queue depth sets the input stall: in_stall rises while three or more
// results wait. When the receiver stalls, the head result holds and input
// items are accepted until three results wait; then in_stall is raised.
// Reset clears the queue and returns the parser to the method phase; an
// accepted end_of_stream item resets the parser after its end marker.
module http_request_tokenizer_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_stream,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic [2:0]      token_kind,
    output logic            token_end,
    output logic            closed_early,
    output logic            last_of_run
);

    logic [2:0] phase_reg, phase_next;
    logic       held_colon_reg, held_colon_next;
    logic       held_cr_reg, held_cr_next;
    logic       line_empty_reg, line_empty_next;

    httptok_pkg::result_t queue_reg [4];
    logic [1:0] wp_reg, wp_next;
    logic [1:0] rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;

    httptok_pkg::result_t res_c [2];
    logic [1:0] n_c;
    logic       in_acc, out_acc;
    logic [1:0] push_cnt;

    assign in_stall = (cnt_reg >= 3'd3);
    assign in_acc = in_valid && !in_stall;
    assign out_valid = (cnt_reg != 3'd0);
    assign out_acc = out_valid && !out_stall;
    assign push_cnt = in_acc ? n_c : 2'd0;

    always_comb
    begin
        logic       done;
        logic [2:0] kind;
        done = 1'b0;
        kind = httptok_pkg::KIND_BODY;
        n_c = 2'd0;
        res_c[0] = '0;
        res_c[1] = '0;
        phase_next = phase_reg;
        held_colon_next = held_colon_reg;
        held_cr_next = held_cr_reg;
        line_empty_next = line_empty_reg;
        if (end_of_stream)
        begin
            kind = (phase_reg > httptok_pkg::KIND_BODY) ? httptok_pkg::KIND_BODY : phase_reg;
            if (held_cr_reg)
            begin
                res_c[n_c[0]] = httptok_pkg::make_result(httptok_pkg::CH_CR, 1'b1, kind,
                                                         1'b0, 1'b0);
                n_c = n_c + 2'd1;
            end
            if (held_colon_reg)
            begin
                res_c[n_c[0]] = httptok_pkg::make_result(httptok_pkg::CH_COLON, 1'b1, kind,
                                                         1'b0, 1'b0);
                n_c = n_c + 2'd1;
            end
            res_c[n_c[0]] = httptok_pkg::make_result(8'h00, 1'b0, kind, 1'b1,
                                                     kind < httptok_pkg::KIND_BODY);
            n_c = n_c + 2'd1;
            phase_next = httptok_pkg::KIND_METHOD;
            held_colon_next = 1'b0;
            held_cr_next = 1'b0;
            line_empty_next = 1'b1;
        end
        else
        begin
            case (phase_reg)
                httptok_pkg::KIND_METHOD, httptok_pkg::KIND_TARGET:
                begin
                    if (in_byte == httptok_pkg::CH_SPACE)
                    begin
                        res_c[0] = httptok_pkg::make_result(8'h00, 1'b0, phase_reg, 1'b1, 1'b0);
                        phase_next = phase_reg + 3'd1;
                    end
                    else
                    begin
                        res_c[0] = httptok_pkg::make_result(in_byte, 1'b1, phase_reg,
                                                            1'b0, 1'b0);
                    end
                    n_c = 2'd1;
                end
                httptok_pkg::KIND_VERSION, httptok_pkg::KIND_VALUE:
                begin
                    if (held_cr_reg)
                    begin
                        held_cr_next = 1'b0;
                        if (in_byte == httptok_pkg::CH_LF)
                        begin
                            res_c[0] = httptok_pkg::make_result(8'h00, 1'b0, phase_reg,
                                                                1'b1, 1'b0);
                            n_c = 2'd1;
                            phase_next = httptok_pkg::KIND_NAME;
                            line_empty_next = 1'b1;
                            done = 1'b1;
                        end
                        else
                        begin
                            res_c[0] = httptok_pkg::make_result(httptok_pkg::CH_CR, 1'b1,
                                                                phase_reg, 1'b0, 1'b0);
                            n_c = 2'd1;
                        end
                    end
                    if (!done)
                    begin
                        if (in_byte == httptok_pkg::CH_CR)
                        begin
                            held_cr_next = 1'b1;
                        end
                        else
                        begin
                            res_c[n_c[0]] = httptok_pkg::make_result(in_byte, 1'b1, phase_reg,
                                                                     1'b0, 1'b0);
                            n_c = n_c + 2'd1;
                        end
                    end
                end
                httptok_pkg::KIND_NAME:
                begin
                    if (held_cr_reg)
                    begin
                        held_cr_next = 1'b0;
                        if (in_byte == httptok_pkg::CH_LF)
                        begin
                            phase_next = httptok_pkg::KIND_BODY;
                            line_empty_next = 1'b1;
                            done = 1'b1;
                        end
                        else
                        begin
                            res_c[0] = httptok_pkg::make_result(httptok_pkg::CH_CR, 1'b1,
                                httptok_pkg::KIND_NAME, 1'b0, 1'b0);
                            n_c = 2'd1;
                            line_empty_next = 1'b0;
                        end
                    end
                    if (!done && held_colon_reg)
                    begin
                        held_colon_next = 1'b0;
                        if (in_byte == httptok_pkg::CH_SPACE)
                        begin
                            res_c[n_c[0]] = httptok_pkg::make_result(8'h00, 1'b0,
                                httptok_pkg::KIND_NAME, 1'b1, 1'b0);
                            n_c = n_c + 2'd1;
                            phase_next = httptok_pkg::KIND_VALUE;
                            done = 1'b1;
                        end
                        else
                        begin
                            res_c[n_c[0]] = httptok_pkg::make_result(httptok_pkg::CH_COLON,
                                1'b1, httptok_pkg::KIND_NAME, 1'b0, 1'b0);
                            n_c = n_c + 2'd1;
                        end
                    end
                    if (!done)
                    begin
                        if (in_byte == httptok_pkg::CH_CR && line_empty_next)
                        begin
                            held_cr_next = 1'b1;
                        end
                        else
                        begin
                            line_empty_next = 1'b0;
                            if (in_byte == httptok_pkg::CH_COLON)
                            begin
                                held_colon_next = 1'b1;
                            end
                            else
                            begin
                                res_c[n_c[0]] = httptok_pkg::make_result(in_byte, 1'b1,
                                    httptok_pkg::KIND_NAME, 1'b0, 1'b0);
                                n_c = n_c + 2'd1;
                            end
                        end
                    end
                end
                default:
                begin
                    res_c[0] = httptok_pkg::make_result(in_byte, 1'b1, httptok_pkg::KIND_BODY,
                                                        1'b0, 1'b0);
                    n_c = 2'd1;
                end
            endcase
        end
        if (n_c == 2'd2)
        begin
            res_c[1].last_of_run = 1'b1;
        end
        else if (n_c == 2'd1)
        begin
            res_c[0].last_of_run = 1'b1;
        end
    end

    always_comb
    begin
        wp_next = wp_reg + push_cnt;
        rp_next = rp_reg + {1'b0, out_acc};
        cnt_next = cnt_reg + {1'b0, push_cnt} - {2'b00, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= httptok_pkg::KIND_METHOD;
            held_colon_reg <= 1'b0;
            held_cr_reg <= 1'b0;
            line_empty_reg <= 1'b1;
            wp_reg <= 2'd0;
            rp_reg <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            if (in_acc)
            begin
                phase_reg <= phase_next;
                held_colon_reg <= held_colon_next;
                held_cr_reg <= held_cr_next;
                line_empty_reg <= line_empty_next;
            end
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            queue_reg[wp_reg] <= res_c[0];
        end
        if (push_cnt == 2'd2)
        begin
            queue_reg[wp_reg + 2'd1] <= res_c[1];
        end
    end

    always_comb
    begin
        out_byte = queue_reg[rp_reg].out_byte;
        byte_valid = queue_reg[rp_reg].byte_valid;
        token_kind = queue_reg[rp_reg].token_kind;
        token_end = queue_reg[rp_reg].token_end;
        closed_early = queue_reg[rp_reg].closed_early;
        last_of_run = queue_reg[rp_reg].last_of_run;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("result queue count out of range");

    a_eos_resets: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && end_of_stream |=> phase_reg == httptok_pkg::KIND_METHOD
            && !held_cr_reg && !held_colon_reg && line_empty_reg)
        else $error("parser state not cleared after end of stream");

    a_colon_in_name: assert property (@(posedge clk) disable iff (!rst_n)
        held_colon_reg |-> phase_reg == httptok_pkg::KIND_NAME && !held_cr_reg)
        else $error("held colon outside header name");

    a_cr_phase: assert property (@(posedge clk) disable iff (!rst_n)
        held_cr_reg |-> phase_reg == httptok_pkg::KIND_VERSION
            || phase_reg == httptok_pkg::KIND_NAME || phase_reg == httptok_pkg::KIND_VALUE)
        else $error("held CR in a phase that cannot hold it");

endmodule

`default_nettype wire

// ----- bench/httptok_token_checker.sv -----
`default_nettype none

module httptok_token_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_stream,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] out_byte,
    input  wire logic       byte_valid,
    input  wire logic [2:0] token_kind,
    input  wire logic       token_end,
    input  wire logic       closed_early,
    input  wire logic       last_of_run,
    output int              mismatch_count,
    output int              tokens_pending
);

    localparam int MAX_TOKENS_PER_ITEM = 2;

    logic [2:0] phase;
    logic       held_colon;
    logic       held_cr;
    logic       line_empty;

    httptok_pkg::result_t step_tokens [MAX_TOKENS_PER_ITEM];
    int                   step_count;
    httptok_pkg::result_t expected_tokens [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] token mismatch: %s got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic reset_parser();
        phase = httptok_pkg::KIND_METHOD;
        held_colon = 1'b0;
        held_cr = 1'b0;
        line_empty = 1'b1;
    endtask

    task automatic emit_token(input logic [7:0] b, input logic v, input logic [2:0] k,
                              input logic e, input logic c);
        if (step_count < MAX_TOKENS_PER_ITEM)
        begin
            step_tokens[step_count].out_byte = b;
            step_tokens[step_count].byte_valid = v;
            step_tokens[step_count].token_kind = k;
            step_tokens[step_count].token_end = e;
            step_tokens[step_count].closed_early = c;
            step_tokens[step_count].last_of_run = 1'b0;
            step_count++;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        case (phase)
            httptok_pkg::KIND_METHOD, httptok_pkg::KIND_TARGET:
            begin
                if (b == httptok_pkg::CH_SPACE)
                begin
                    emit_token(8'h00, 1'b0, phase, 1'b1, 1'b0);
                    phase = phase + 3'd1;
                end
                else
                begin
                    emit_token(b, 1'b1, phase, 1'b0, 1'b0);
                end
            end
            httptok_pkg::KIND_VERSION, httptok_pkg::KIND_VALUE:
            begin
                if (held_cr)
                begin
                    held_cr = 1'b0;
                    if (b == httptok_pkg::CH_LF)
                    begin
                        emit_token(8'h00, 1'b0, phase, 1'b1, 1'b0);
                        phase = httptok_pkg::KIND_NAME;
                        line_empty = 1'b1;
                        return;
                    end
                    emit_token(httptok_pkg::CH_CR, 1'b1, phase, 1'b0, 1'b0);
                end
                if (b == httptok_pkg::CH_CR)
                    held_cr = 1'b1;
                else
                    emit_token(b, 1'b1, phase, 1'b0, 1'b0);
            end
            httptok_pkg::KIND_NAME:
            begin
                if (held_cr)
                begin
                    held_cr = 1'b0;
                    // blank line: headers done, no token
                    if (b == httptok_pkg::CH_LF)
                    begin
                        phase = httptok_pkg::KIND_BODY;
                        line_empty = 1'b1;
                        return;
                    end
                    emit_token(httptok_pkg::CH_CR, 1'b1, httptok_pkg::KIND_NAME, 1'b0, 1'b0);
                    line_empty = 1'b0;
                end
                if (held_colon)
                begin
                    held_colon = 1'b0;
                    if (b == httptok_pkg::CH_SPACE)
                    begin
                        emit_token(8'h00, 1'b0, httptok_pkg::KIND_NAME, 1'b1, 1'b0);
                        phase = httptok_pkg::KIND_VALUE;
                        return;
                    end
                    emit_token(httptok_pkg::CH_COLON, 1'b1, httptok_pkg::KIND_NAME,
                               1'b0, 1'b0);
                end
                if (b == httptok_pkg::CH_CR && line_empty)
                begin
                    held_cr = 1'b1;
                    return;
                end
                line_empty = 1'b0;
                if (b == httptok_pkg::CH_COLON)
                    held_colon = 1'b1;
                else
                    emit_token(b, 1'b1, httptok_pkg::KIND_NAME, 1'b0, 1'b0);
            end
            default:
            begin
                emit_token(b, 1'b1, httptok_pkg::KIND_BODY, 1'b0, 1'b0);
            end
        endcase
    endtask

    task automatic predict_item(input logic [7:0] b, input logic eos);
        logic [2:0] kind;
        step_count = 0;
        if (eos)
        begin
            kind = (phase > httptok_pkg::KIND_BODY) ? httptok_pkg::KIND_BODY : phase;
            if (held_cr)
                emit_token(httptok_pkg::CH_CR, 1'b1, kind, 1'b0, 1'b0);
            if (held_colon)
                emit_token(httptok_pkg::CH_COLON, 1'b1, kind, 1'b0, 1'b0);
            emit_token(8'h00, 1'b0, kind, 1'b1, kind < httptok_pkg::KIND_BODY);
            reset_parser();
        end
        else
        begin
            parse_byte(b);
        end
        for (int i = 0; i < step_count; i++)
        begin
            if (i == step_count - 1)
                step_tokens[i].last_of_run = 1'b1;
            expected_tokens.push_back(step_tokens[i]);
        end
    endtask

    task automatic check_output();
        httptok_pkg::result_t want;
        if (expected_tokens.size() == 0)
        begin
            report_mismatch("result with nothing expected, out_byte", out_byte, 0);
            return;
        end
        want = expected_tokens.pop_front();
        if (out_byte != want.out_byte)
            report_mismatch("out_byte", out_byte, want.out_byte);
        if (byte_valid != want.byte_valid)
            report_mismatch("byte_valid", byte_valid, want.byte_valid);
        if (token_kind != want.token_kind)
            report_mismatch("token_kind", token_kind, want.token_kind);
        if (token_end != want.token_end)
            report_mismatch("token_end", token_end, want.token_end);
        if (closed_early != want.closed_early)
            report_mismatch("closed_early", closed_early, want.closed_early);
        if (last_of_run != want.last_of_run)
            report_mismatch("last_of_run", last_of_run, want.last_of_run);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_parser();
            expected_tokens.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_item(in_byte, end_of_stream);
            if (out_valid && !out_stall)
                check_output();
        end
        tokens_pending = expected_tokens.size();
    end

endmodule

`default_nettype wire

// ----- bench/tb_http_request_tokenizer_core.sv -----
`default_nettype none

module tb_http_request_tokenizer_core;

    localparam int ITEM_TARGET = 1300;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN_CYCLES = 20;
    localparam int EOS_MARK = -1;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       end_of_stream = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] token_kind;
    logic       token_end;
    logic       closed_early;
    logic       last_of_run;
    int         mismatch_count;
    int         tokens_pending;

    logic [7:0] feed_bytes [$];
    logic       feed_eos [$];

    http_request_tokenizer_core i_dut (.*);

    httptok_token_checker i_check (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic add_byte(input logic [7:0] b);
        feed_bytes.push_back(b);
        feed_eos.push_back(1'b0);
    endtask

    task automatic add_eos();
        feed_bytes.push_back(8'($urandom_range(0, 255)));
        feed_eos.push_back(1'b1);
    endtask

    function automatic logic [7:0] text_byte(input logic [7:0] avoid);
        logic [7:0] c;
        c = 8'($urandom_range(33, 126));
        if (c == avoid)
            c = "q";
        // occasional stray delimiter or raw byte
        if ($urandom_range(0, 19) == 0)
        begin
            case ($urandom_range(0, 4))
                0: c = httptok_pkg::CH_CR;
                1: c = httptok_pkg::CH_LF;
                2: c = httptok_pkg::CH_COLON;
                3: c = httptok_pkg::CH_SPACE;
                default: c = 8'($urandom);
            endcase
        end
        return c;
    endfunction

    task automatic add_directed();
        int script [30] = '{
            8'hFF, httptok_pkg::CH_CR, httptok_pkg::CH_SPACE, 8'h00, httptok_pkg::CH_SPACE,
            httptok_pkg::CH_CR, "x", httptok_pkg::CH_CR, httptok_pkg::CH_LF,
            httptok_pkg::CH_COLON, "x", httptok_pkg::CH_COLON, httptok_pkg::CH_SPACE, 8'h80,
            httptok_pkg::CH_CR, httptok_pkg::CH_LF,
            httptok_pkg::CH_CR, "z", httptok_pkg::CH_COLON, EOS_MARK,
            "A", httptok_pkg::CH_SPACE, httptok_pkg::CH_SPACE, httptok_pkg::CH_SPACE,
            httptok_pkg::CH_CR, httptok_pkg::CH_LF,
            httptok_pkg::CH_CR, httptok_pkg::CH_LF, httptok_pkg::CH_CR, EOS_MARK
        };
        foreach (script[i])
        begin
            if (script[i] == EOS_MARK)
                add_eos();
            else
                add_byte(script[i][7:0]);
        end
    endtask

    task automatic add_request();
        logic [7:0] req [$];
        int keep;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(0, 40)) req.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 6)) req.push_back(text_byte(httptok_pkg::CH_SPACE));
            req.push_back(httptok_pkg::CH_SPACE);
            repeat ($urandom_range(0, 8)) req.push_back(text_byte(httptok_pkg::CH_SPACE));
            req.push_back(httptok_pkg::CH_SPACE);
            repeat ($urandom_range(0, 8)) req.push_back(text_byte(httptok_pkg::CH_CR));
            req.push_back(httptok_pkg::CH_CR);
            req.push_back(httptok_pkg::CH_LF);
            repeat ($urandom_range(0, 4))
            begin
                repeat ($urandom_range(1, 6)) req.push_back(text_byte(httptok_pkg::CH_COLON));
                req.push_back(httptok_pkg::CH_COLON);
                req.push_back(httptok_pkg::CH_SPACE);
                repeat ($urandom_range(0, 8)) req.push_back(text_byte(httptok_pkg::CH_CR));
                req.push_back(httptok_pkg::CH_CR);
                req.push_back(httptok_pkg::CH_LF);
            end
            req.push_back(httptok_pkg::CH_CR);
            req.push_back(httptok_pkg::CH_LF);
            repeat ($urandom_range(0, 12)) req.push_back(8'($urandom_range(0, 255)));
            // connection dropped part way
            if ($urandom_range(0, 5) == 0)
            begin
                keep = $urandom_range(0, req.size());
                while (req.size() > keep)
                    void'(req.pop_back());
            end
        end
        foreach (req[i])
            add_byte(req[i]);
        add_eos();
    endtask

    initial
    begin
        int idx;
        int burst;
        int gap;
        add_directed();
        while (feed_bytes.size() < ITEM_TARGET)
            add_request();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idx = 0;
        while (idx < feed_bytes.size())
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                burst = 40;
                gap = 0;
            end
            else
            begin
                burst = $urandom_range(1, 16);
                gap = $urandom_range(0, 6);
            end
            for (int k = 0; k < burst && idx < feed_bytes.size(); k++)
            begin
                in_valid <= 1'b1;
                in_byte <= feed_bytes[idx];
                end_of_stream <= feed_eos[idx];
                @(posedge clk);
                while (in_stall)
                    @(posedge clk);
                idx++;
            end
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        wait (tokens_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && tokens_pending == 0)
            $display("http_request_tokenizer_core regression: pass");
        else
            $display("http_request_tokenizer_core regression: fail");
        $finish;
    end

    initial
    begin
        int seg;
        int len;
        int mode;
        seg = 0;
        forever
        begin
            // long hold so the result queue fills and the input stalls
            if (seg == 4 || seg == 30)
            begin
                repeat (HOLD_CYCLES)
                begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
            end
            else
            begin
                mode = $urandom_range(0, 3);
                len = $urandom_range(20, 80);
                for (int k = 0; k < len; k++)
                begin
                    @(posedge clk);
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= 1'($urandom_range(0, 1));
                        2: out_stall <= (k % 3 == 0);
                        default: out_stall <= ($urandom_range(0, 4) != 0);
                    endcase
                end
            end
            seg++;
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("http_request_tokenizer_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ----- http_request_tokenizer_core.f -----
rtl/core/httptok_pkg.sv
rtl/core/http_request_tokenizer_core.sv
bench/httptok_token_checker.sv
bench/tb_http_request_tokenizer_core.sv
